### rtl/rtun_pkg.sv
// Shared widths, payload types and arithmetic steps of the triangle normal unit.
`default_nettype none
package rtun_pkg;

    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int OUT_W            = 16;
    localparam int CFG_W            = 32;

    localparam int EDGE_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W  = PROD_W;
    localparam int HALF_W = MAG_W / 2;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int ROOT_W = (SQ_W + 3) / 2;
    localparam int SUM_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int Q_W    = NORMAL_FRAC_BITS + 1;
    localparam int DIV_W  = MAG_W + NORMAL_FRAC_BITS + 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] p0_x, p0_y, p0_z;
        logic signed [COORD_BITS-1:0] p1_x, p1_y, p1_z;
        logic signed [COORD_BITS-1:0] p2_x, p2_y, p2_z;
    } triangle_t;

    // cross product as sign and magnitude per component
    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
    } cvec_t;

    typedef struct packed {
        cvec_t             vec;
        logic [ROOT_W-1:0] len;
        logic              deg;
    } job_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x, normal_y, normal_z;
        logic                    ok;
    } result_t;

    typedef struct packed {
        logic [SUM_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    // one digit of the integer square root
    function automatic sqrt_t sqrt_step(input sqrt_t s);
        sqrt_t            r;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        rem_sh = {s.rem[REM_W-3:0], s.rad[SUM_W-1:SUM_W-2]};
        trial  = {s.root, 2'b01};
        r.rad  = {s.rad[SUM_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            r.rem  = rem_sh - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else begin
            r.rem  = rem_sh;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/rtun_if.sv
// Valid/ready channels carrying triangles in and unit normals out.
`default_nettype none
interface rtun_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rtun_pkg::COORD_BITS-1:0] p0_x, p0_y, p0_z;
    logic signed [rtun_pkg::COORD_BITS-1:0] p1_x, p1_y, p1_z;
    logic signed [rtun_pkg::COORD_BITS-1:0] p2_x, p2_y, p2_z;
    modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                    input ready);
    modport sink (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                  output ready);
endinterface

interface rtun_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [rtun_pkg::OUT_W-1:0] normal_x, normal_y, normal_z;
    logic                             ok;
    modport source (output valid, normal_x, normal_y, normal_z, ok, input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, ok, output ready);
endinterface
`default_nettype wire

### rtl/robust_triangle_unit_normal.sv
// Top level of the triangle unit normal block: front, job queue, back.
//
// Usage: triangles (three Q8.8 points) enter on tri_in, one item per cycle while
// tri_in.ready is high; each gives exactly one item on norm_out: the unit normal of
// (P0-P2) x (P1-P0) in Q1.14 with ok=1, or a zero vector with ok=0 when the
// cross-product length is zero or below min_cross_length (Q16.16).
// cfg_we/cfg_wdata write min_cross_length; write it only while the block is
// idle. Reset sets it to 1.
// Pipeline: 6 front stages for edges, products, cross, split squares and sum,
// then one stage per root bit (35) of the square root, the queue, a load
// stage, 15 divider stages and the output register. Throughput: one item per
// cycle while norm_out is ready and the queue has room; every stage of both
// pipelines is its own register.
// Stalls: when norm_out is not ready the back pipeline holds; the front keeps
// accepting until the four-entry queue is full and a finished job waits, then tri_in.ready drops.
// Reset empties the pipelines and the queue; no clearing pass is needed.
`default_nettype none
module robust_triangle_unit_normal (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    rtun_in_if.sink                          tri_in,
    rtun_out_if.source                       norm_out,
    input  wire logic                        cfg_we,
    input  wire logic [rtun_pkg::CFG_W-1:0]  cfg_wdata
);

    logic [rtun_pkg::CFG_W-1:0] min_cross_length_reg;
    rtun_pkg::triangle_t        tri_data;
    rtun_pkg::job_t             fr_job, q_job;
    logic                       fr_valid, fr_ready, q_valid, q_ready;
    rtun_pkg::result_t          res;

    // hold the threshold; the user must write it only when idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            min_cross_length_reg <= rtun_pkg::CFG_W'(1);
        end
        else if (cfg_we) begin
            min_cross_length_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        tri_data.p0_x = tri_in.p0_x;
        tri_data.p0_y = tri_in.p0_y;
        tri_data.p0_z = tri_in.p0_z;
        tri_data.p1_x = tri_in.p1_x;
        tri_data.p1_y = tri_in.p1_y;
        tri_data.p1_z = tri_in.p1_z;
        tri_data.p2_x = tri_in.p2_x;
        tri_data.p2_y = tri_in.p2_y;
        tri_data.p2_z = tri_in.p2_z;
    end

    rtun_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tri_in.valid),
        .in_ready  (tri_in.ready),
        .in_tri    (tri_data),
        .min_len   (min_cross_length_reg),
        .job_valid (fr_valid),
        .job_ready (fr_ready),
        .job       (fr_job)
    );

    rtun_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_data  (fr_job),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_job)
    );

    rtun_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .res_valid (norm_out.valid),
        .res_ready (norm_out.ready),
        .res       (res)
    );

    assign norm_out.normal_x = res.normal_x;
    assign norm_out.normal_y = res.normal_y;
    assign norm_out.normal_z = res.normal_z;
    assign norm_out.ok       = res.ok;

    // a degenerate triangle gives the zero vector
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (norm_out.valid && !norm_out.ok) |->
            (norm_out.normal_x == '0 && norm_out.normal_y == '0 && norm_out.normal_z == '0))
        else $error("degenerate result carries a non-zero normal");

    // a valid normal is never the zero vector
    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (norm_out.valid && norm_out.ok) |->
            (norm_out.normal_x != '0 || norm_out.normal_y != '0 || norm_out.normal_z != '0))
        else $error("valid result carries the zero vector");

    // no component exceeds one in magnitude
    a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        norm_out.valid |->
            ($signed(norm_out.normal_x) <= 16384 && $signed(norm_out.normal_x) >= -16384 &&
             $signed(norm_out.normal_y) <= 16384 && $signed(norm_out.normal_y) >= -16384 &&
             $signed(norm_out.normal_z) <= 16384 && $signed(norm_out.normal_z) >= -16384))
        else $error("normal component out of range");

endmodule
`default_nettype wire

### rtl/rtun_front.sv
// Front pipeline: edges, cross product, squared length, square root, degeneracy test.
`default_nettype none
module rtun_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire rtun_pkg::triangle_t          in_tri,
    input  wire logic [rtun_pkg::CFG_W-1:0]   min_len,
    output logic                              job_valid,
    input  wire logic                         job_ready,
    output rtun_pkg::job_t                    job
);

    localparam int NR = rtun_pkg::ROOT_W;

    logic adv;

    logic                                          s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                                          s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic signed [2:0][rtun_pkg::EDGE_W-1:0]       s1_a_reg, s1_b_reg;
    logic signed [5:0][rtun_pkg::PROD_W-1:0]       s2_prod_reg;
    logic signed [2:0][rtun_pkg::CROSS_W-1:0]      s3_cross_reg;
    rtun_pkg::cvec_t                               s4_vec_reg, s5_vec_reg, s6_vec_reg;
    logic [2:0][2*rtun_pkg::HALF_W-1:0]            s4_hh_reg, s4_hl_reg, s4_ll_reg;
    logic [2:0][rtun_pkg::SQ_W-1:0]                s5_sq_reg;
    logic [rtun_pkg::SUM_W-1:0]                    s6_sum_reg;

    logic [NR-1:0]         rt_valid_reg;
    rtun_pkg::sqrt_t       rt_reg [NR];
    rtun_pkg::cvec_t       rt_vec_reg [NR];
    rtun_pkg::sqrt_t       rt_next [NR];

    rtun_pkg::cvec_t                  mag_next;
    logic [rtun_pkg::CROSS_W-1:0]     abs_c;

    // stall only when a finished job cannot enter the queue
    assign adv      = !(rt_valid_reg[NR-1] && !job_ready);
    assign in_ready = adv;

    always_comb
    begin
        rtun_pkg::sqrt_t seed;
        seed.rad  = s6_sum_reg;
        seed.rem  = '0;
        seed.root = '0;
        for (int k = 0; k < NR; k++) begin
            rt_next[k] = rtun_pkg::sqrt_step((k == 0) ? seed : rt_reg[(k == 0) ? 0 : k-1]);
        end
    end

    always_comb
    begin
        abs_c = '0;
        for (int i = 0; i < 3; i++) begin
            mag_next.neg[i] = s3_cross_reg[i][rtun_pkg::CROSS_W-1];
            abs_c = mag_next.neg[i] ? rtun_pkg::CROSS_W'(-s3_cross_reg[i])
                                    : rtun_pkg::CROSS_W'(s3_cross_reg[i]);
            mag_next.mag[i] = abs_c[rtun_pkg::MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            rt_valid_reg <= '0;
        end
        else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            rt_valid_reg <= {rt_valid_reg[NR-2:0], s6_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            // V1 = P0 - P2, V2 = P1 - P0
            s1_a_reg[0] <= rtun_pkg::EDGE_W'(in_tri.p0_x) - rtun_pkg::EDGE_W'(in_tri.p2_x);
            s1_a_reg[1] <= rtun_pkg::EDGE_W'(in_tri.p0_y) - rtun_pkg::EDGE_W'(in_tri.p2_y);
            s1_a_reg[2] <= rtun_pkg::EDGE_W'(in_tri.p0_z) - rtun_pkg::EDGE_W'(in_tri.p2_z);
            s1_b_reg[0] <= rtun_pkg::EDGE_W'(in_tri.p1_x) - rtun_pkg::EDGE_W'(in_tri.p0_x);
            s1_b_reg[1] <= rtun_pkg::EDGE_W'(in_tri.p1_y) - rtun_pkg::EDGE_W'(in_tri.p0_y);
            s1_b_reg[2] <= rtun_pkg::EDGE_W'(in_tri.p1_z) - rtun_pkg::EDGE_W'(in_tri.p0_z);

            // elements of a packed array select unsigned: take them as signed
            s2_prod_reg[0] <= $signed(s1_a_reg[1]) * $signed(s1_b_reg[2]);
            s2_prod_reg[1] <= $signed(s1_a_reg[2]) * $signed(s1_b_reg[1]);
            s2_prod_reg[2] <= $signed(s1_a_reg[2]) * $signed(s1_b_reg[0]);
            s2_prod_reg[3] <= $signed(s1_a_reg[0]) * $signed(s1_b_reg[2]);
            s2_prod_reg[4] <= $signed(s1_a_reg[0]) * $signed(s1_b_reg[1]);
            s2_prod_reg[5] <= $signed(s1_a_reg[1]) * $signed(s1_b_reg[0]);

            for (int i = 0; i < 3; i++) begin
                s3_cross_reg[i] <= rtun_pkg::CROSS_W'($signed(s2_prod_reg[2*i]))
                                 - rtun_pkg::CROSS_W'($signed(s2_prod_reg[2*i+1]));
            end

            // split each magnitude in halves for the square
            s4_vec_reg <= mag_next;
            for (int i = 0; i < 3; i++) begin
                s4_hh_reg[i] <= mag_next.mag[i][rtun_pkg::MAG_W-1:rtun_pkg::HALF_W]
                              * mag_next.mag[i][rtun_pkg::MAG_W-1:rtun_pkg::HALF_W];
                s4_hl_reg[i] <= mag_next.mag[i][rtun_pkg::MAG_W-1:rtun_pkg::HALF_W]
                              * mag_next.mag[i][rtun_pkg::HALF_W-1:0];
                s4_ll_reg[i] <= mag_next.mag[i][rtun_pkg::HALF_W-1:0]
                              * mag_next.mag[i][rtun_pkg::HALF_W-1:0];
            end

            s5_vec_reg <= s4_vec_reg;
            for (int i = 0; i < 3; i++) begin
                s5_sq_reg[i] <= (rtun_pkg::SQ_W'(s4_hh_reg[i]) << (2 * rtun_pkg::HALF_W))
                              + (rtun_pkg::SQ_W'(s4_hl_reg[i]) << (rtun_pkg::HALF_W + 1))
                              + rtun_pkg::SQ_W'(s4_ll_reg[i]);
            end

            s6_vec_reg <= s5_vec_reg;
            s6_sum_reg <= rtun_pkg::SUM_W'(s5_sq_reg[0]) + rtun_pkg::SUM_W'(s5_sq_reg[1])
                        + rtun_pkg::SUM_W'(s5_sq_reg[2]);

            for (int k = 0; k < NR; k++) begin
                rt_reg[k]     <= rt_next[k];
                rt_vec_reg[k] <= (k == 0) ? s6_vec_reg : rt_vec_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_comb
    begin
        job_valid = rt_valid_reg[NR-1];
        job.vec   = rt_vec_reg[NR-1];
        job.len   = rt_reg[NR-1].root;
        job.deg   = (rt_reg[NR-1].root == '0)
                 || (rt_reg[NR-1].root < rtun_pkg::ROOT_W'(min_len));
    end

endmodule
`default_nettype wire

### rtl/rtun_fifo.sv
// Short job queue between the front and back pipelines.
`default_nettype none
module rtun_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    input  wire rtun_pkg::job_t wr_data,
    output logic                rd_valid,
    input  wire logic           rd_ready,
    output rtun_pkg::job_t      rd_data
);

    rtun_pkg::job_t                   mem_reg [rtun_pkg::FIFO_DEPTH];
    logic [rtun_pkg::FIFO_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [rtun_pkg::FIFO_CW-1:0]     count_reg, count_next;
    logic                             push, pop;

    assign wr_ready = count_reg != rtun_pkg::FIFO_CW'(rtun_pkg::FIFO_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

### rtl/rtun_back.sv
// Back pipeline: per-component restoring division, saturation, sign and output register.
`default_nettype none
module rtun_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            job_valid,
    output logic                 job_ready,
    input  wire rtun_pkg::job_t  job,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output rtun_pkg::result_t    res
);

    localparam int NQ = rtun_pkg::Q_W;
    localparam int RW = rtun_pkg::ROOT_W;

    typedef struct packed {
        logic [2:0]                  neg;
        logic                        deg;
        logic [RW-1:0]               len;
        logic [2:0][RW-1:0]          rem;
        logic [2:0][NQ-1:0]          dlow;
        logic [2:0][NQ-1:0]          q;
    } divst_t;

    logic               adv;
    logic               b0_valid_reg;
    divst_t             b0_reg;
    logic [NQ-1:0]      dv_valid_reg;
    divst_t             dv_reg [NQ];
    divst_t             dv_next [NQ];
    divst_t             b0_next;
    logic               out_valid_reg;
    rtun_pkg::result_t  out_reg, out_next;

    assign adv       = !out_valid_reg || res_ready;
    assign job_ready = adv;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // load: dividend = |c| * 2^F + L/2, remainder starts from its top bits
    always_comb
    begin
        logic [rtun_pkg::DIV_W-1:0] dvd;
        dvd = '0;
        b0_next.neg = job.vec.neg;
        b0_next.deg = job.deg;
        b0_next.len = job.len;
        b0_next.q   = '0;
        for (int i = 0; i < 3; i++) begin
            dvd = (rtun_pkg::DIV_W'(job.vec.mag[i]) << rtun_pkg::NORMAL_FRAC_BITS)
                + rtun_pkg::DIV_W'(job.len >> 1);
            b0_next.rem[i]  = RW'(dvd >> NQ);
            b0_next.dlow[i] = dvd[NQ-1:0];
        end
    end

    always_comb
    begin
        divst_t        src;
        logic [RW:0]   rem_sh;
        src    = b0_reg;
        rem_sh = '0;
        for (int k = 0; k < NQ; k++) begin
            src = (k == 0) ? b0_reg : dv_reg[(k == 0) ? 0 : k-1];
            dv_next[k] = src;
            for (int i = 0; i < 3; i++) begin
                rem_sh = {src.rem[i], src.dlow[i][NQ-1]};
                dv_next[k].dlow[i] = {src.dlow[i][NQ-2:0], 1'b0};
                if (rem_sh >= {1'b0, src.len}) begin
                    dv_next[k].rem[i] = RW'(rem_sh - {1'b0, src.len});
                    dv_next[k].q[i]   = {src.q[i][NQ-2:0], 1'b1};
                end
                else begin
                    dv_next[k].rem[i] = rem_sh[RW-1:0];
                    dv_next[k].q[i]   = {src.q[i][NQ-2:0], 1'b0};
                end
            end
        end
    end

    // clamp to one, apply the sign, zero a degenerate triangle
    always_comb
    begin
        logic [2:0][rtun_pkg::OUT_W-1:0] comp;
        logic [NQ-1:0]                   qs;
        comp = '0;
        qs   = '0;
        for (int i = 0; i < 3; i++) begin
            qs = dv_reg[NQ-1].q[i];
            if (qs > NQ'(1) << rtun_pkg::NORMAL_FRAC_BITS) begin
                qs = NQ'(1) << rtun_pkg::NORMAL_FRAC_BITS;
            end
            comp[i] = dv_reg[NQ-1].neg[i] ? rtun_pkg::OUT_W'(-rtun_pkg::OUT_W'(qs))
                                          : rtun_pkg::OUT_W'(qs);
            if (dv_reg[NQ-1].deg) begin
                comp[i] = '0;
            end
        end
        out_next.normal_x = comp[0];
        out_next.normal_y = comp[1];
        out_next.normal_z = comp[2];
        out_next.ok       = !dv_reg[NQ-1].deg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            b0_valid_reg  <= 1'b0;
            dv_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv) begin
            b0_valid_reg  <= job_valid;
            dv_valid_reg  <= {dv_valid_reg[NQ-2:0], b0_valid_reg};
            out_valid_reg <= dv_valid_reg[NQ-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            b0_reg  <= b0_next;
            for (int k = 0; k < NQ; k++) begin
                dv_reg[k] <= dv_next[k];
            end
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire
